@@ hw/rtl/sbds_pkg.sv @@
// Shared constants, tables and types for the spectrum bin dB smoother.
package sbds_pkg;

  // Store geometry and transform size
  localparam int NUM_BINS       = 512;
  localparam int TRANSFORM_SIZE = 1024;
  localparam int ADDR_W         = $clog2(NUM_BINS);

  // Field widths
  localparam int IDX_W   = 9;
  localparam int LEVEL_W = 16;
  localparam int LOG_W   = 23;

  // Smoothing factor limits (Q0.16)
  localparam logic [15:0] FACTOR_MAX   = 16'd64880;
  localparam logic [15:0] FACTOR_RESET = 16'd52429;

  // 10*log10(2)/80 in Q0.20
  localparam int DB_SLOPE = 39457;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [16:0]        frac_t;

  // log2(1 + k/16) in Q0.16, k = 0..16
  localparam frac_t FRAC_TABLE [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52910, 17'd56228, 17'd59433, 17'd62534, 17'd65536
  };

  // Elaboration-time log2 in Q.16 of a small positive constant
  function automatic int log2_q16_const(input int x);
    int e;
    int t;
    int m;
    int k;
    int r;
    int lo;
    int hi;
    e = 0;
    t = x;
    while (t > 1) begin
      t = t >> 1;
      e = e + 1;
    end
    if (e >= 16) m = (x >> (e - 16)) & 32'hFFFF;
    else         m = (x << (16 - e)) & 32'hFFFF;
    k  = m >> 12;
    r  = m & 32'hFFF;
    lo = int'(FRAC_TABLE[k]);
    hi = int'(FRAC_TABLE[k+1]);
    return e * 65536 + lo + (((hi - lo) * r) >> 12);
  endfunction

  localparam int LOG_TS = log2_q16_const(TRANSFORM_SIZE);

  // Result of the level pipeline
  typedef struct packed {
    idx_t   idx;
    level_t level;
  } lvl_res_t;

endpackage

@@ hw/rtl/sbds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sbds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sbds_level.sv @@
// Nine-stage pipeline from a complex bin to its normalized dB level.
module sbds_level
  import sbds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  idx_t               bin_index,
  input  logic signed [31:0] bin_re,
  input  logic signed [31:0] bin_im,
  output logic               res_valid,
  input  logic               res_ready,
  output lvl_res_t           res
);

  localparam logic signed [16:0] SLOPE_S = 17'(DB_SLOPE);
  localparam logic signed [23:0] LOG_TS2 = 24'(2 * LOG_TS);
  localparam logic signed [41:0] BIAS    = 42'((64'd1 << 36) + (64'd1 << 19));

  // Highest set bit of a 16-bit chunk
  function automatic logic [3:0] msb16(input logic [15:0] x);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) p = 4'(i);
    end
    return p;
  endfunction

  // Per-stage valid and enable
  logic [9:1] v;
  logic [9:1] en;

  always_comb begin
    en[9] = !v[9] || res_ready;
    for (int i = 8; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int i = 2; i <= 9; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Index rides along every stage
  idx_t idx [1:9];

  always_ff @(posedge clk) begin
    if (en[1]) idx[1] <= bin_index;
    for (int i = 2; i <= 9; i++) begin
      if (en[i]) idx[i] <= idx[i-1];
    end
  end

  // Stage 1: magnitudes of both parts
  logic [31:0] are1, aim1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      are1 <= bin_re[31] ? (~bin_re + 32'd1) : bin_re;
      aim1 <= bin_im[31] ? (~bin_im + 32'd1) : bin_im;
    end
  end

  // Stage 2: squares
  logic [63:0] re2, im2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      re2 <= are1 * are1;
      im2 <= aim1 * aim1;
    end
  end

  // Stage 3: power
  logic [63:0] pow3;

  always_ff @(posedge clk) begin
    if (en[3]) pow3 <= re2 + im2;
  end

  // Stage 4: leading one inside each 16-bit chunk
  logic [63:0] pow4;
  logic [3:0]  nz4;
  logic [3:0]  pos4 [4];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pow4 <= pow3;
      for (int c = 0; c < 4; c++) begin
        nz4[c]  <= |pow3[16*c +: 16];
        pos4[c] <= msb16(pow3[16*c +: 16]);
      end
    end
  end

  // Stage 5: exponent from the highest nonzero chunk
  logic [5:0]  e_next;
  logic [5:0]  e5;
  logic [63:0] pow5;
  logic        zero5;

  always_comb begin
    e_next = 6'd0;
    for (int c = 0; c < 4; c++) begin
      if (nz4[c]) e_next = {2'(c), pos4[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      e5    <= e_next;
      pow5  <= pow4;
      zero5 <= ~|nz4;
    end
  end

  // Stage 6: mantissa bits below the leading one, table lookup
  logic [63:0] norm6;
  logic [15:0] mant;
  logic [4:0]  k_lo;
  logic [4:0]  k_hi;
  logic [5:0]  e6;
  frac_t       lo6;
  logic [12:0] diff6;
  logic [11:0] r6;
  logic        zero6;

  always_comb begin
    norm6 = pow5 << (6'd63 - e5);
    mant  = norm6[62:47];
    k_lo  = {1'b0, mant[15:12]};
    k_hi  = k_lo + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      e6    <= e5;
      lo6   <= FRAC_TABLE[k_lo];
      diff6 <= 13'(FRAC_TABLE[k_hi] - FRAC_TABLE[k_lo]);
      r6    <= mant[11:0];
      zero6 <= zero5;
    end
  end

  // Stage 7: interpolated log2 in Q.16
  logic [24:0]      interp;
  logic [LOG_W-1:0] log7;
  logic             zero7;

  assign interp = diff6 * r6;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      log7  <= {1'b0, e6, 16'd0} + LOG_W'(lo6) + LOG_W'(interp[24:12]);
      zero7 <= zero6;
    end
  end

  // Stage 8: relative to full scale, times the dB slope
  logic signed [23:0] d8;
  logic signed [40:0] prod8;
  logic               zero8;

  assign d8 = $signed({1'b0, log7}) - LOG_TS2;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      prod8 <= d8 * SLOPE_S;
      zero8 <= zero7;
    end
  end

  // Stage 9: offset, round and saturate
  logic signed [41:0] t9;
  level_t             level_next;
  level_t             level9;

  always_comb begin
    t9 = 42'(prod8) + BIAS;
    if (zero8 || t9 <= 42'sd0) begin
      level_next = '0;
    end else if (|t9[40:36]) begin
      level_next = '1;
    end else begin
      level_next = t9[35:20];
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) level9 <= level_next;
  end

  assign res_valid = v[9];
  assign res.idx   = idx[9];
  assign res.level = level9;

endmodule

@@ hw/rtl/spectrum_bin_db_smoother.sv @@
// Top level of the spectrum bin dB smoother: level pipeline, smoothing stage, store.
//
// Takes one FFT bin per cycle, unless out_ready holds the pipeline, and returns
// its dB level, mapped from -80..0 dB onto 0..1 in Q0.16, with the
// exponentially smoothed level of that bin. A request is accepted every cycle
// once the store is cleared, unless the output stalls. The rate is set by the
// single multiply-add that updates the stored average, which closes with the
// previous result forwarded, so requests for the same bin may follow each
// other directly. After reset a clearing pass writes zero into all 512 store
// entries, one per cycle, and no request is accepted until it is done; factor
// writes are taken throughout. Factor writes above 0.99 store 0.99.
module spectrum_bin_db_smoother
  import sbds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  idx_t               bin_index,
  input  logic signed [31:0] bin_re,
  input  logic signed [31:0] bin_im,
  output logic               out_valid,
  input  logic               out_ready,
  output idx_t               bin_out,
  output level_t             level,
  output level_t             smoothed_level
);

  // Smoothing factor register, clamped on write
  logic [15:0] factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RESET;
    end else if (cfg_we) begin
      factor <= (cfg_wdata > FACTOR_MAX) ? FACTOR_MAX : cfg_wdata;
    end
  end

  // Clearing pass over the store after reset
  logic [ADDR_W:0] clr_cnt;
  logic            clr_done;

  assign clr_done = (clr_cnt == (ADDR_W+1)'(NUM_BINS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!clr_done) begin
      clr_cnt <= clr_cnt + (ADDR_W+1)'(1);
    end
  end

  // Level pipeline
  logic     lm_ready;
  logic     lv_valid;
  logic     lv_ready;
  lvl_res_t lv;

  assign in_ready = clr_done && lm_ready;

  sbds_level u_level (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid && clr_done),
    .in_ready  (lm_ready),
    .bin_index (bin_index),
    .bin_re    (bin_re),
    .bin_im    (bin_im),
    .res_valid (lv_valid),
    .res_ready (lv_ready),
    .res       (lv)
  );

  // Stage enables
  logic en10;
  logic en_out;
  logic v10;

  assign en_out   = !out_valid || out_ready;
  assign en10     = !v10 || en_out;
  assign lv_ready = en10;

  // Store write and read ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  level_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  level_t            ram_rdata;
  logic              upd_we;
  logic [ADDR_W-1:0] upd_addr;
  level_t            upd_new;

  assign ram_raddr = ADDR_W'(lv.idx);
  assign ram_we    = !clr_done || upd_we;
  assign ram_waddr = clr_done ? upd_addr : clr_cnt[ADDR_W-1:0];
  assign ram_wdata = clr_done ? upd_new : '0;

  sbds_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (NUM_BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en10),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage 10: new-sample term, store read, forward of a same-cycle write
  idx_t        idx10;
  logic        inr10;
  level_t      level10;
  logic [32:0] gl10;
  logic        byp10;
  level_t      bypd10;
  logic [16:0] wgt;

  assign wgt = 17'h10000 - {1'b0, factor};

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en10) begin
      v10 <= lv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en10) begin
      idx10   <= lv.idx;
      inr10   <= (32'(lv.idx) < 32'(NUM_BINS));
      level10 <= lv.level;
      gl10    <= wgt * lv.level;
      byp10   <= ram_we && (ram_waddr == ram_raddr);
      bypd10  <= ram_wdata;
    end
  end

  // Stage 11: average update, written back as it leaves
  level_t      old_avg;
  logic [32:0] acc;

  assign old_avg  = byp10 ? bypd10 : ram_rdata;
  assign acc      = factor * old_avg + gl10 + 33'd32768;
  assign upd_new  = acc[31:16];
  assign upd_addr = ADDR_W'(idx10);
  assign upd_we   = en_out && v10 && inr10;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      bin_out        <= idx10;
      level          <= level10;
      smoothed_level <= inr10 ? upd_new : '0;
    end
  end

  // Checks
  a_no_upd_during_clear: assert property (@(posedge clk) disable iff (rst)
    !clr_done |-> !upd_we)
    else $error("store update while clearing");

  a_no_result_during_clear: assert property (@(posedge clk) disable iff (rst)
    !clr_done |-> !out_valid && !v10)
    else $error("result in flight while clearing");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(bin_out) >= 32'(NUM_BINS)) |-> smoothed_level == '0)
    else $error("smoothed level for bin outside the store");

endmodule

@@ verif/tb_spectrum_bin_db_smoother.sv @@
// Testbench for spectrum_bin_db_smoother: directed table, random bins, per-field checks.
`timescale 1ns / 100ps

module tb_spectrum_bin_db_smoother
  import sbds_pkg::*;
();

  localparam int STALL_LIMIT   = 4000;
  localparam int RESULT_LAT    = 12;
  localparam int PHASE_ITEMS   = 340;
  localparam int IDLE_PCT      = 38;

  typedef struct {
    idx_t   idx;
    level_t lvl;
    level_t smo;
  } bin_result_t;

  typedef struct {
    idx_t               idx;
    logic signed [31:0] re;
    logic signed [31:0] im;
    bit                 known;
    level_t             lvl;
    level_t             smo;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  idx_t               bin_index;
  logic signed [31:0] bin_re;
  logic signed [31:0] bin_im;
  logic               out_valid;
  logic               out_ready;
  idx_t               bin_out;
  level_t             level;
  level_t             smoothed_level;

  // Predictor state
  level_t      avg_mem [NUM_BINS];
  logic [15:0] weight_old;
  bin_result_t pending_bins [$];

  int  mismatch_count;
  int  stall_cycles;
  bit  calm;

  // Directed requests; fresh bins at the reset weight give level/average by hand
  dir_row_t dir_rows [16] = '{
    '{9'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     16'd0},
    '{9'd511, 32'h0000_0400, 32'h0000_0000, 1'b1, 16'd65535, 16'd13107},
    '{9'd1,   32'h8000_0000, 32'h8000_0000, 1'b1, 16'd65535, 16'd13107},
    '{9'd2,   32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'd65535, 16'd13107},
    '{9'd3,   32'h0000_0001, 32'h0000_0000, 1'b0, 16'd0,     16'd0},
    '{9'd3,   32'h0000_0000, 32'h0000_0001, 1'b0, 16'd0,     16'd0},
    '{9'd3,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0,     16'd0},
    '{9'd511, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0,     16'd0},
    '{9'd4,   32'h0000_03FF, 32'h0000_0000, 1'b0, 16'd0,     16'd0},
    '{9'd4,   32'h0000_0000, 32'hFFFF_FC00, 1'b0, 16'd0,     16'd0},
    '{9'd5,   32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'd0,     16'd0},
    '{9'd6,   32'h0001_0000, 32'h0001_0000, 1'b0, 16'd0,     16'd0},
    '{9'd7,   32'h0000_0064, 32'h0000_0000, 1'b0, 16'd0,     16'd0},
    '{9'h155, 32'h0000_FFFF, 32'h7FFF_0000, 1'b0, 16'd0,     16'd0},
    '{9'h0AA, 32'h8000_0001, 32'h0000_0001, 1'b0, 16'd0,     16'd0},
    '{9'd3,   32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0,     16'd0}
  };

  spectrum_bin_db_smoother DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .bin_index      (bin_index),
    .bin_re         (bin_re),
    .bin_im         (bin_im),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bin_out        (bin_out),
    .level          (level),
    .smoothed_level (smoothed_level)
  );

  always #5 clk = ~clk;

  // log2 in Q.16: leading one plus interpolated fraction table
  function automatic int unsigned log2_fix(longint unsigned x);
    int unsigned lead;
    int unsigned mant;
    int unsigned seg;
    int unsigned rem;
    int unsigned lo;
    int unsigned hi;
    lead = 0;
    for (int b = 0; b < 64; b++)
      if (x[b]) lead = b;
    if (lead >= 16) mant = int'((x >> (lead - 16)) & 64'hFFFF);
    else            mant = int'((x << (16 - lead)) & 64'hFFFF);
    seg = mant >> 12;
    rem = mant & 32'hFFF;
    lo  = FRAC_TABLE[seg];
    hi  = FRAC_TABLE[seg + 1];
    return lead * 65536 + lo + (((hi - lo) * rem) >> 12);
  endfunction

  // Power in dB, mapped -80..0 dB onto Q0.16 with saturation
  function automatic level_t db_level(logic signed [31:0] re, logic signed [31:0] im);
    longint          sre;
    longint          sim;
    longint unsigned pwr;
    longint          d;
    longint          t;
    sre = re;
    sim = im;
    if (sre < 0) sre = -sre;
    if (sim < 0) sim = -sim;
    pwr = longint'(sre * sre) + longint'(sim * sim);
    if (pwr == 0) return '0;
    d = longint'(log2_fix(pwr)) - 2 * longint'(log2_fix(TRANSFORM_SIZE));
    t = d * DB_SLOPE + (longint'(65536) <<< 20) + (longint'(1) <<< 19);
    if (t <= 0) return '0;
    t = t >>> 20;
    if (t > 65535) return 16'hFFFF;
    return level_t'(t);
  endfunction

  // Level plus exponential update of this bin's average
  function automatic bin_result_t predict_bin(idx_t idx, logic signed [31:0] re,
                                              logic signed [31:0] im);
    bin_result_t     r;
    longint unsigned acc;
    r.idx = idx;
    r.lvl = db_level(re, im);
    r.smo = '0;
    if (idx < NUM_BINS) begin
      acc = longint'(weight_old) * avg_mem[idx] + (65536 - longint'(weight_old)) * r.lvl
            + 32768;
      r.smo = acc[31:16];
      avg_mem[idx] = r.smo;
    end
    return r;
  endfunction

  // One request on the input channel, with random idling before it outside calm stretches
  task automatic send_bin(idx_t idx, logic signed [31:0] re, logic signed [31:0] im,
                          bit known, level_t lvl, level_t smo);
    bin_result_t r;
    if (!calm)
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid  <= 1'b1;
    bin_index <= idx;
    bin_re    <= re;
    bin_im    <= im;
    do @(posedge clk); while (!(in_valid && in_ready));
    r = predict_bin(idx, re, im);
    if (known) begin
      r.lvl = lvl;
      r.smo = smo;
    end
    pending_bins.push_back(r);
    @(negedge clk);
  endtask

  // Hold off until every outstanding request has returned, then let the pipe empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(negedge clk);
    repeat (RESULT_LAT) @(negedge clk);
  endtask

  task automatic write_weight(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    weight_old = (value > FACTOR_MAX) ? FACTOR_MAX : value;
  endtask

  // Component value spread over magnitudes, with zeros and extremes
  function automatic logic signed [31:0] rand_part();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1: begin
        case ($urandom_range(3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      2, 3:    v = $urandom;
      default: v = $signed($urandom) >>> $urandom_range(31);
    endcase
    return v;
  endfunction

  function automatic idx_t rand_bin();
    case ($urandom_range(7))
      0, 1, 2, 3: return idx_t'($urandom_range(7));
      4:          return $urandom_range(1) ? idx_t'(511) : idx_t'(0);
      default:    return idx_t'($urandom_range(NUM_BINS - 1));
    endcase
  endfunction

  // Output ready, stalled at random unless in a calm stretch
  always @(negedge clk)
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  // Result checker
  always @(posedge clk) begin
    bin_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_bins.size() == 0) begin
        $error("unexpected result: bin_out=%0d level=%0d smoothed_level=%0d",
               bin_out, level, smoothed_level);
        mismatch_count++;
      end else begin
        e = pending_bins.pop_front();
        if (bin_out !== e.idx) begin
          $error("bin_out: expected %0d, got %0d", e.idx, bin_out);
          mismatch_count++;
        end
        if (level !== e.lvl) begin
          $error("level: expected %0d, got %0d", e.lvl, level);
          mismatch_count++;
        end
        if (smoothed_level !== e.smo) begin
          $error("smoothed_level: expected %0d, got %0d", e.smo, smoothed_level);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] weights [6];
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    bin_index      = '0;
    bin_re         = '0;
    bin_im         = '0;
    out_ready      = 1'b0;
    calm           = 1'b0;
    mismatch_count = 0;
    stall_cycles   = 0;
    weight_old     = FACTOR_RESET;
    foreach (avg_mem[i]) avg_mem[i] = '0;
    weights = '{16'd0, FACTOR_MAX, 16'hFFFF, 16'd1, 16'd32768, 16'($urandom)};

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed table at the reset weight
    foreach (dir_rows[i])
      send_bin(dir_rows[i].idx, dir_rows[i].re, dir_rows[i].im,
               dir_rows[i].known, dir_rows[i].lvl, dir_rows[i].smo);

    // Random phases, one weight setting each
    foreach (weights[p]) begin
      drain_results();
      write_weight(weights[p]);
      calm = (p == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_bin(rand_bin(), rand_part(), rand_part(), 1'b0, '0, '0);
      end
    end
    calm = 1'b0;

    drain_results();
    if (mismatch_count == 0 && pending_bins.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
